@@ sv/tpim_pkg.sv @@
package tpim_pkg;

    localparam int MAX_AXES       = 4;
    localparam int INDEX_BITS     = 20;
    localparam int STEP_BITS      = INDEX_BITS + 1;
    localparam int REG_AXES       = 4;
    localparam int DIV_AXES       = REG_AXES - 1;
    localparam int AXES_LIMIT     = (MAX_AXES < REG_AXES) ? MAX_AXES : REG_AXES;
    localparam int COUNT_BITS     = 3;
    localparam int ORDER_BITS     = 2 * REG_AXES;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = STEP_BITS;

    // Input register, then per divided axis one stage per quotient bit plus a
    // multiply and an accumulate stage, then multiply and accumulate for the last axis.
    localparam int AXIS_STAGES = INDEX_BITS + 2;
    localparam int PIPE_STAGES = 1 + DIV_AXES * AXIS_STAGES + 2;

    localparam logic [COUNT_BITS-1:0] AXIS_COUNT_RESET = 3'd4;
    localparam logic [ORDER_BITS-1:0] AXIS_ORDER_RESET = 8'd228;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_AXIS_COUNT   = 4'd0,
        CFG_AXIS_ORDER   = 4'd1,
        CFG_OUT_STEP_0   = 4'd2,
        CFG_OUT_STEP_1   = 4'd3,
        CFG_OUT_STEP_2   = 4'd4,
        CFG_SRC_STRIDE_0 = 4'd5,
        CFG_SRC_STRIDE_1 = 4'd6,
        CFG_SRC_STRIDE_2 = 4'd7
    } cfg_addr_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]              axis_count;
        logic [ORDER_BITS-1:0]              axis_order;
        logic [DIV_AXES-1:0][STEP_BITS-1:0] out_step;
        logic [DIV_AXES-1:0][STEP_BITS-1:0] src_stride;
    } cfg_t;

    // work holds the partial remainder in the upper half and the dividend
    // bits, which turn into quotient bits, in the lower half.
    typedef struct packed {
        logic [2*INDEX_BITS-1:0] work;
        logic [INDEX_BITS-1:0]   sum;
        logic [INDEX_BITS-1:0]   prod;
    } stage_t;

    typedef struct packed {
        logic [STEP_BITS-1:0]  divisor;
        logic                  zero;
        logic [INDEX_BITS-1:0] stride;
    } axis_param_t;

    function automatic logic [COUNT_BITS-1:0] axes_in_use(input logic [COUNT_BITS-1:0] count);
        logic [COUNT_BITS-1:0] n;
        n = count;
        if (n == '0)
            n = COUNT_BITS'(1);
        if (int'(n) > AXES_LIMIT)
            n = COUNT_BITS'(AXES_LIMIT);
        return n;
    endfunction

    // Output step of a divided axis; the last axis in use always divides by one.
    function automatic logic [STEP_BITS-1:0] axis_divisor(input cfg_t cfg, input int j);
        logic [COUNT_BITS-1:0] n;
        logic [STEP_BITS-1:0]  d;
        n = axes_in_use(cfg.axis_count);
        if (j + 1 >= int'(n))
            d = STEP_BITS'(1);
        else
            d = cfg.out_step[j];
        return d;
    endfunction

    // Source stride of the axis that output axis j reads.
    function automatic logic [INDEX_BITS-1:0] axis_stride(input cfg_t cfg, input int j);
        logic [COUNT_BITS-1:0] n;
        logic [1:0]            a;
        logic [COUNT_BITS-1:0] ax;
        logic [STEP_BITS-1:0]  s;
        n  = axes_in_use(cfg.axis_count);
        a  = cfg.axis_order[2*j +: 2];
        ax = COUNT_BITS'(a);
        if (ax >= n)
            s = '0;
        else if (ax + COUNT_BITS'(1) == n)
            s = STEP_BITS'(1);
        else begin
            case (a)
                2'd0:    s = cfg.src_stride[0];
                2'd1:    s = cfg.src_stride[1];
                2'd2:    s = cfg.src_stride[2];
                default: s = STEP_BITS'(1);
            endcase
        end
        return s[INDEX_BITS-1:0];
    endfunction

endpackage

@@ sv/tpim_if.sv @@
interface tpim_idx_if;
    logic                              valid;
    logic                              ready;
    logic [tpim_pkg::INDEX_BITS-1:0]   out_index;

    modport source (output valid, output out_index, input ready);
    modport sink   (input valid, input out_index, output ready);
endinterface

interface tpim_addr_if;
    logic                              valid;
    logic                              ready;
    logic [tpim_pkg::INDEX_BITS-1:0]   src_index;

    modport source (output valid, output src_index, input ready);
    modport sink   (input valid, input src_index, output ready);
endinterface

interface tpim_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [tpim_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [tpim_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/tpim_div_step.sv @@
module tpim_div_step (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           valid_in,
    input  tpim_pkg::stage_t               data_in,
    input  logic [tpim_pkg::STEP_BITS-1:0] divisor,
    output logic                           valid_out,
    output tpim_pkg::stage_t               data_out
);

    localparam int IB = tpim_pkg::INDEX_BITS;

    logic [tpim_pkg::STEP_BITS-1:0] hi;
    logic [tpim_pkg::STEP_BITS-1:0] diff;
    logic                           take;
    tpim_pkg::stage_t               data_next;
    tpim_pkg::stage_t               data_reg;
    logic                           valid_reg;

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    always_comb
    begin
        hi        = data_in.work[2*IB-1:IB-1];
        take      = (hi >= divisor);
        diff      = take ? (hi - divisor) : hi;
        data_next = data_in;
        data_next.work = {diff[IB-1:0], data_in.work[IB-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ sv/tpim_mul_stage.sv @@
module tpim_mul_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  tpim_pkg::stage_t      data_in,
    input  tpim_pkg::axis_param_t param,
    output logic                  valid_out,
    output tpim_pkg::stage_t      data_out
);

    localparam int IB = tpim_pkg::INDEX_BITS;

    logic [IB-1:0]    quot;
    logic [IB-1:0]    rem;
    logic [IB-1:0]    prod;
    tpim_pkg::stage_t data_next;
    tpim_pkg::stage_t data_reg;
    logic             valid_reg;

    // A zero step leaves the dividend in the remainder half and adds nothing.
    always_comb
    begin
        quot      = data_in.work[IB-1:0];
        rem       = data_in.work[2*IB-1:IB];
        prod      = quot * param.stride;
        data_next = data_in;
        data_next.prod = param.zero ? '0 : prod;
        data_next.work = {{IB{1'b0}}, rem};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ sv/tpim_acc_stage.sv @@
module tpim_acc_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  tpim_pkg::stage_t data_in,
    output logic             valid_out,
    output tpim_pkg::stage_t data_out
);

    tpim_pkg::stage_t data_next;
    tpim_pkg::stage_t data_reg;
    logic             valid_reg;

    // The sum wraps at the index width.
    always_comb
    begin
        data_next     = data_in;
        data_next.sum = data_in.sum + data_in.prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ sv/tensor_permute_index_map_core.sv @@
// Throughput: one request per cycle, except while a result waits at the output and is not taken.
// The restoring divider yields one quotient bit per stage.
// The input register takes one more request, if it is empty, while a result waits at the output.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the register
// reset values: four axes, identity axis order, all steps and strides one.
module tensor_permute_index_map_core (
    input  logic         clk,
    input  logic         rst_n,
    tpim_cfg_if.sink     cfg,
    tpim_idx_if.sink     idx,
    tpim_addr_if.source  addr
);

    localparam int IB = tpim_pkg::INDEX_BITS;
    localparam int S  = tpim_pkg::PIPE_STAGES;

    // Configuration registers. Software must write them only while the pipeline is
    // empty; the block does not enforce this. Every stage reads them directly, with no copy.
    tpim_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.axis_count <= tpim_pkg::AXIS_COUNT_RESET;
            cfg_reg.axis_order <= tpim_pkg::AXIS_ORDER_RESET;
            for (int i = 0; i < tpim_pkg::DIV_AXES; i++) begin
                cfg_reg.out_step[i]   <= tpim_pkg::STEP_BITS'(1);
                cfg_reg.src_stride[i] <= tpim_pkg::STEP_BITS'(1);
            end
        end
        else if (cfg.valid) begin
            unique case (tpim_pkg::cfg_addr_t'(cfg.index))
                tpim_pkg::CFG_AXIS_COUNT:
                    cfg_reg.axis_count <= cfg.data[tpim_pkg::COUNT_BITS-1:0];
                tpim_pkg::CFG_AXIS_ORDER:
                    cfg_reg.axis_order <= cfg.data[tpim_pkg::ORDER_BITS-1:0];
                tpim_pkg::CFG_OUT_STEP_0:   cfg_reg.out_step[0]   <= cfg.data;
                tpim_pkg::CFG_OUT_STEP_1:   cfg_reg.out_step[1]   <= cfg.data;
                tpim_pkg::CFG_OUT_STEP_2:   cfg_reg.out_step[2]   <= cfg.data;
                tpim_pkg::CFG_SRC_STRIDE_0: cfg_reg.src_stride[0] <= cfg.data;
                tpim_pkg::CFG_SRC_STRIDE_1: cfg_reg.src_stride[1] <= cfg.data;
                tpim_pkg::CFG_SRC_STRIDE_2: cfg_reg.src_stride[2] <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // Per-axis divisor and stride, decoded once from the registers. The last
    // axis in use divides by one, so it leaves a zero remainder and every axis
    // after it contributes nothing. Axis three never divides: its quotient is
    // whatever remainder axis two leaves.
    tpim_pkg::axis_param_t par [tpim_pkg::REG_AXES];

    always_comb
    begin
        for (int j = 0; j < tpim_pkg::DIV_AXES; j++) begin
            par[j].divisor = tpim_pkg::axis_divisor(cfg_reg, j);
            par[j].zero    = (par[j].divisor == '0);
            par[j].stride  = tpim_pkg::axis_stride(cfg_reg, j);
        end
        par[tpim_pkg::DIV_AXES].divisor = tpim_pkg::STEP_BITS'(1);
        par[tpim_pkg::DIV_AXES].zero    = 1'b0;
        par[tpim_pkg::DIV_AXES].stride  = tpim_pkg::axis_stride(cfg_reg, tpim_pkg::DIV_AXES);
    end

    // Pipeline. All stages past the input register move together on en, which
    // drops only while a result sits at the output and is not taken. The input
    // register also loads whenever it is empty, so one more request is taken
    // during a stall.
    logic [S-1:0]     pipe_valid;
    tpim_pkg::stage_t pipe_data [S];
    logic             en;
    logic             s0_en;
    logic             s0_valid_reg;
    tpim_pkg::stage_t s0_data_reg;

    assign en    = !pipe_valid[S-1] || addr.ready;
    assign s0_en = en || !s0_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s0_en)
            s0_valid_reg <= idx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s0_en) begin
            s0_data_reg.work <= {{IB{1'b0}}, idx.out_index};
            s0_data_reg.sum  <= '0;
            s0_data_reg.prod <= '0;
        end
    end

    assign idx.ready     = s0_en;
    assign pipe_valid[0] = s0_valid_reg;
    assign pipe_data[0]  = s0_data_reg;

    // Each divided axis: one stage per quotient bit, then the product of the
    // quotient and the source stride, then the running sum.
    for (genvar j = 0; j < tpim_pkg::DIV_AXES; j++) begin : g_axis
        localparam int BASE = 1 + j * tpim_pkg::AXIS_STAGES;

        for (genvar k = 0; k < IB; k++) begin : g_bit
            tpim_div_step u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .valid_in  (pipe_valid[BASE+k-1]),
                .data_in   (pipe_data[BASE+k-1]),
                .divisor   (par[j].divisor),
                .valid_out (pipe_valid[BASE+k]),
                .data_out  (pipe_data[BASE+k])
            );
        end

        tpim_mul_stage u_mul (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (pipe_valid[BASE+IB-1]),
            .data_in   (pipe_data[BASE+IB-1]),
            .param     (par[j]),
            .valid_out (pipe_valid[BASE+IB]),
            .data_out  (pipe_data[BASE+IB])
        );

        tpim_acc_stage u_acc (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (pipe_valid[BASE+IB]),
            .data_in   (pipe_data[BASE+IB]),
            .valid_out (pipe_valid[BASE+IB+1]),
            .data_out  (pipe_data[BASE+IB+1])
        );
    end

    // Last axis: the work word already holds its quotient in the lower half.
    tpim_mul_stage u_mul_last (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (pipe_valid[S-3]),
        .data_in   (pipe_data[S-3]),
        .param     (par[tpim_pkg::DIV_AXES]),
        .valid_out (pipe_valid[S-2]),
        .data_out  (pipe_data[S-2])
    );

    tpim_acc_stage u_acc_last (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (pipe_valid[S-2]),
        .data_in   (pipe_data[S-2]),
        .valid_out (pipe_valid[S-1]),
        .data_out  (pipe_data[S-1])
    );

    // The last stage is the output register.
    assign addr.valid     = pipe_valid[S-1];
    assign addr.src_index = pipe_data[S-1].sum;

    logic in_acc;
    logic out_acc;

    assign in_acc  = idx.valid && idx.ready;
    assign out_acc = addr.valid && addr.ready;

    // Requests in flight change only by what enters and what leaves.
    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            $countones(pipe_valid) ==
            $past($countones(pipe_valid)) + int'($past(in_acc)) - int'($past(out_acc)))
        else $error("request lost or duplicated in pipeline");

    // During a stall everything past the input register holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(pipe_valid[S-1:1]))
        else $error("pipeline moved during a stall");

    // After the last quotient bit the remainder is below a nonzero divisor.
    for (genvar j = 0; j < tpim_pkg::DIV_AXES; j++) begin : g_chk
        localparam int LAST = j * tpim_pkg::AXIS_STAGES + IB;

        a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
            (pipe_valid[LAST] && (par[j].divisor != '0)) |->
                ({1'b0, pipe_data[LAST].work[2*IB-1:IB]} < par[j].divisor))
            else $error("divider remainder not below divisor");
    end

endmodule
